// ===== rtl/sorted_set_insert_lookup_unit_assert.svh =====
// assertion macros for the sorted set unit
// expects clk and rst_n in the scope of the module that uses them
`ifndef SORTED_SET_INSERT_LOOKUP_UNIT_ASSERT_SVH
`define SORTED_SET_INSERT_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssi_pkg.sv =====
// shared constants and types for the sorted set unit
// no dependencies
`default_nettype none

package ssi_pkg;

    // store size and key width
    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;

    // width of the internal entry count and of the count port
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int COUNT_WIDTH = 5;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // control broadcast to every cell
    typedef struct packed {
        logic cmp_en;       // capture compare flags against the incoming key
        logic shift_en;     // commit the insert into the row
        logic signed_mode;  // two's complement ordering
    } ssi_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ssi_cell.sv =====
// one entry of the sorted row: holds a key, compares and shifts
// depends on ssi_pkg
`default_nettype none

module ssi_cell
    import ssi_pkg::*;
(
    input  wire logic                 clk,
    input  wire ssi_ctrl_t            ctrl,
    input  wire logic                 valid,
    input  wire logic [KEY_WIDTH-1:0] cmp_key,
    input  wire logic [KEY_WIDTH-1:0] ins_key,
    input  wire logic [KEY_WIDTH-1:0] left_key,
    input  wire logic                 gt_in,
    input  wire logic                 eq_in,
    output logic      [KEY_WIDTH-1:0] key_out,
    output logic                      gt_out,
    output logic                      eq_out
);

    localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    logic [KEY_WIDTH-1:0] key_reg;
    logic                 eq_reg;
    logic                 gt_reg;
    logic [KEY_WIDTH-1:0] flip;
    logic [KEY_WIDTH-1:0] new_ord;
    logic [KEY_WIDTH-1:0] own_ord;
    logic                 eq_next;
    logic                 gt_next;
    logic [KEY_WIDTH-1:0] key_next;

    // map both keys so that unsigned order is the selected order
    always_comb
    begin
        flip    = ctrl.signed_mode ? SIGN_BIT : '0;
        new_ord = cmp_key ^ flip;
        own_ord = key_reg ^ flip;
        eq_next = valid && (cmp_key == key_reg);
        gt_next = valid && (new_ord < own_ord);
    end

    // compare flags for the item in flight
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            eq_reg <= eq_next;
            gt_reg <= gt_next;
        end
    end

    // shift up behind the insert point, take the key at it or at the end
    always_comb
    begin
        key_next = key_reg;
        if (gt_in)
        begin
            key_next = left_key;
        end
        else if (gt_reg || !valid)
        begin
            key_next = ins_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift_en)
        begin
            key_reg <= key_next;
        end
    end

    // prefix chains toward the right neighbor
    assign key_out = key_reg;
    assign gt_out  = gt_in || gt_reg;
    assign eq_out  = eq_in || eq_reg;

endmodule

`default_nettype wire

// ===== rtl/sorted_set_insert_lookup_unit.sv =====
// Sorted set of up to CAPACITY distinct keys kept in ascending order in a row
// of cells. For each item, at the accepting edge every cell
// compares its key with the incoming key at once; in the next cycle the
// "found" and "first greater entry" flags ripple along the cell chain and the
// row shifts up by one behind the insert point. The result appears on the
// result ports with done high for exactly one cycle after that, and busy is
// low in that same cycle, so start may follow. The receiver cannot stall;
// results must be taken when done is high. The user must write compare_signed
// through cfg_we/cfg_wdata only while the unit is idle; the unit does not enforce this.
// depends on ssi_pkg, ssi_cell and sorted_set_insert_lookup_unit_assert.svh
`default_nettype none

`include "sorted_set_insert_lookup_unit_assert.svh"

module sorted_set_insert_lookup_unit
    import ssi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_wdata,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   operation,
    input  wire logic [31:0]            key,
    output logic                        done,
    output logic                        found,
    output logic                        inserted,
    output logic                        full_drop,
    output logic [COUNT_WIDTH-1:0]      count
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic                 signed_reg;
    logic                 op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 done_reg;
    logic                 found_reg;
    logic                 inserted_reg;
    logic                 full_drop_reg;

    logic                 accept;
    logic                 is_full;
    logic                 do_insert;
    logic                 found_all;
    ssi_ctrl_t            ctrl;
    logic [KEY_WIDTH-1:0] in_key;

    logic [CAPACITY-1:0]  valid;
    logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
    logic [CAPACITY:0]    gt_chain;
    logic [CAPACITY:0]    eq_chain;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign in_key    = key[KEY_WIDTH-1:0];
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign found_all = eq_chain[CAPACITY];
    assign do_insert = (state_reg == ST_UPDATE) && (op_reg == OP_INSERT)
                       && !found_all && !is_full;

    // cell control
    always_comb
    begin
        ctrl.cmp_en      = accept;
        ctrl.shift_en    = do_insert;
        ctrl.signed_mode = signed_reg;
    end

    // chain ends
    assign gt_chain[0] = 1'b0;
    assign eq_chain[0] = 1'b0;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left;

        assign valid[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign left = key_reg;
        end
        else
        begin : g_rest
            assign left = cell_key[i-1];
        end

        ssi_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .valid    (valid[i]),
            .cmp_key  (in_key),
            .ins_key  (key_reg),
            .left_key (left),
            .gt_in    (gt_chain[i]),
            .eq_in    (eq_chain[i]),
            .key_out  (cell_key[i]),
            .gt_out   (gt_chain[i+1]),
            .eq_out   (eq_chain[i+1])
        );
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign count_next = do_insert ? count_reg + CNT_W'(1) : count_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            signed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= (state_reg == ST_UPDATE);
            if (cfg_we)
            begin
                signed_reg <= cfg_wdata;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            key_reg <= in_key;
        end
        if (state_reg == ST_UPDATE)
        begin
            found_reg     <= found_all;
            inserted_reg  <= do_insert;
            full_drop_reg <= (op_reg == OP_INSERT) && !found_all && is_full;
        end
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign inserted  = inserted_reg;
    assign full_drop = full_drop_reg;
    assign count     = COUNT_WIDTH'(count_reg);

    // checks
    `SSI_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SSI_ASSERT_NEXT(a_done_follows, state_reg == ST_UPDATE, done_reg && !busy, "no result after update")
    `SSI_ASSERT_NOW(a_flags_excl, done_reg && found_reg, !inserted_reg && !full_drop_reg, "found with insert flags")
    `SSI_ASSERT_NEXT(a_insert_grows, do_insert, count_reg == CNT_W'($past(count_reg) + 1'b1), "insert did not grow count")
    `SSI_ASSERT_NOW(a_drop_full, done_reg && full_drop_reg, count_reg == CNT_W'(CAPACITY), "drop while not full")

endmodule

`default_nettype wire
